// ===== hdl/armed_quad_motor_mixer_assert.svh =====
// assertion macros for the armed quad motor mixer checker
// expects clk_i and rst_ni in the scope of the use
`ifndef ARMED_QUAD_MOTOR_MIXER_ASSERT_SVH
`define ARMED_QUAD_MOTOR_MIXER_ASSERT_SVH

// checked only out of reset
`define AQMM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define AQMM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/aqmm_pkg.sv =====
// types, register indexes, reset values and clamp helper for the motor mixer
// no dependencies
`default_nettype none

package aqmm_pkg;

  localparam int unsigned RegW  = 9;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned ReqW  = 16;
  localparam int unsigned TermW = 10;
  localparam int unsigned SumW  = 12;
  localparam int unsigned MotW  = 10;

  localparam logic [IdxW-1:0] RegPitchRollLimit = 3'd0;
  localparam logic [IdxW-1:0] RegYawLimit       = 3'd1;
  localparam logic [IdxW-1:0] RegClimbStepLimit = 3'd2;
  localparam logic [IdxW-1:0] RegMinThrottle    = 3'd3;
  localparam logic [IdxW-1:0] RegMaxThrottle    = 3'd4;
  localparam logic [IdxW-1:0] RegMixLimit       = 3'd5;

  localparam logic [RegW-1:0] RstPitchRollLimit = 9'd200;
  localparam logic [RegW-1:0] RstYawLimit       = 9'd1;
  localparam logic [RegW-1:0] RstClimbStepLimit = 9'd3;
  localparam logic [RegW-1:0] RstMinThrottle    = 9'd50;
  localparam logic [RegW-1:0] RstMaxThrottle    = 9'd511;
  localparam logic [RegW-1:0] RstMixLimit       = 9'd511;

  typedef struct packed {
    logic [RegW-1:0] pitch_roll_limit;
    logic [RegW-1:0] yaw_limit;
    logic [RegW-1:0] climb_step_limit;
    logic [RegW-1:0] min_throttle;
    logic [RegW-1:0] max_throttle;
    logic [RegW-1:0] mix_limit;
  } cfg_t;

  typedef struct packed {
    logic                   takeoff;
    logic                   emergency;
    logic signed [ReqW-1:0] pitch;
    logic signed [ReqW-1:0] roll;
    logic signed [ReqW-1:0] yaw;
    logic signed [ReqW-1:0] climb;
  } cmd_t;

  typedef struct packed {
    logic [TermW-1:0]        throttle;
    logic signed [TermW-1:0] pitch;
    logic signed [TermW-1:0] roll;
    logic signed [TermW-1:0] yaw;
    logic                    armed;
  } state_t;

  typedef struct packed {
    logic [MotW-1:0] fwd_l;
    logic [MotW-1:0] fwd_r;
    logic [MotW-1:0] aft_l;
    logic [MotW-1:0] aft_r;
  } motors_t;

  // symmetric clamp of a request to +-lim
  function automatic logic signed [TermW-1:0] clamp_sym(logic signed [ReqW-1:0] x,
                                                        logic [RegW-1:0] lim);
    logic signed [ReqW:0] xw;
    logic signed [ReqW:0] lw;
    logic signed [ReqW:0] r;
    begin
      xw = {x[ReqW-1], x};
      lw = $signed({{(ReqW+1-RegW){1'b0}}, lim});
      if (xw < -lw) begin
        r = -lw;
      end else if (xw > lw) begin
        r = lw;
      end else begin
        r = xw;
      end
      return r[TermW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/aqmm_cfg_regs.sv =====
// configuration register file of the motor mixer
// depends on aqmm_pkg
`default_nettype none

module aqmm_cfg_regs
  import aqmm_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_index_i,
  input  wire logic [RegW-1:0] wr_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        RegPitchRollLimit: cfg_d.pitch_roll_limit = wr_data_i;
        RegYawLimit:       cfg_d.yaw_limit        = wr_data_i;
        RegClimbStepLimit: cfg_d.climb_step_limit = wr_data_i;
        RegMinThrottle:    cfg_d.min_throttle     = wr_data_i;
        RegMaxThrottle:    cfg_d.max_throttle     = wr_data_i;
        RegMixLimit:       cfg_d.mix_limit        = wr_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_roll_limit <= RstPitchRollLimit;
      cfg_q.yaw_limit        <= RstYawLimit;
      cfg_q.climb_step_limit <= RstClimbStepLimit;
      cfg_q.min_throttle     <= RstMinThrottle;
      cfg_q.max_throttle     <= RstMaxThrottle;
      cfg_q.mix_limit        <= RstMixLimit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/aqmm_state.sv =====
// arming flag, throttle and stored pitch, roll and yaw terms
// depends on aqmm_pkg
`default_nettype none

module aqmm_state
  import aqmm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire cmd_t cmd_i,
  input  wire cfg_t cfg_i,
  output state_t    state_d_o
);

  state_t state_q;
  state_t state_d;
  logic signed [TermW-1:0] climb_c;
  logic signed [SumW-1:0]  thr;
  logic signed [SumW-1:0]  thr_min;
  logic signed [SumW-1:0]  thr_max;

  always_comb begin
    climb_c = clamp_sym(cmd_i.climb, cfg_i.climb_step_limit);
    thr_min = $signed({{(SumW-RegW){1'b0}}, cfg_i.min_throttle});
    thr_max = $signed({{(SumW-RegW){1'b0}}, cfg_i.max_throttle});
    thr = $signed({{(SumW-TermW){1'b0}}, state_q.throttle})
        + $signed({{(SumW-TermW){climb_c[TermW-1]}}, climb_c});
    if (thr < thr_min) begin
      thr = thr_min;
    end
    if (thr > thr_max) begin
      thr = thr_max;
    end

    state_d = state_q;
    if (cmd_i.takeoff) begin
      state_d.armed = 1'b1;
    end
    if (cmd_i.emergency) begin
      state_d = '0;
    end else if (state_d.armed) begin
      state_d.pitch    = clamp_sym(cmd_i.pitch, cfg_i.pitch_roll_limit);
      state_d.roll     = clamp_sym(cmd_i.roll, cfg_i.pitch_roll_limit);
      state_d.yaw      = clamp_sym(cmd_i.yaw, cfg_i.yaw_limit);
      state_d.throttle = thr[TermW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign state_d_o = state_d;

endmodule

`default_nettype wire

// ===== hdl/aqmm_mixer.sv =====
// x-frame mix of throttle and terms into four motor speeds
// depends on aqmm_pkg
`default_nettype none

module aqmm_mixer
  import aqmm_pkg::*;
(
  input  wire state_t state_i,
  input  wire cfg_t   cfg_i,
  output motors_t     motors_o
);

  logic signed [SumW-1:0] p;
  logic signed [SumW-1:0] r;
  logic signed [SumW-1:0] y;
  logic signed [SumW-1:0] lim;

  function automatic logic [MotW-1:0] mix_out(logic signed [SumW-1:0] s,
                                              logic signed [SumW-1:0] lim_w,
                                              logic [TermW-1:0] thr);
    logic [SumW-1:0] m;
    begin
      if (s < 0) begin
        m = '0;
      end else if (s > lim_w) begin
        m = lim_w;
      end else begin
        m = s;
      end
      return thr + m[MotW-1:0];
    end
  endfunction

  always_comb begin
    p   = $signed({{(SumW-TermW){state_i.pitch[TermW-1]}}, state_i.pitch});
    r   = $signed({{(SumW-TermW){state_i.roll[TermW-1]}}, state_i.roll});
    y   = $signed({{(SumW-TermW){state_i.yaw[TermW-1]}}, state_i.yaw});
    lim = $signed({{(SumW-RegW){1'b0}}, cfg_i.mix_limit});
    motors_o.fwd_l = mix_out(-p + r - y, lim, state_i.throttle);
    motors_o.fwd_r = mix_out(-p - r + y, lim, state_i.throttle);
    motors_o.aft_l = mix_out(p + r + y, lim, state_i.throttle);
    motors_o.aft_r = mix_out(p - r - y, lim, state_i.throttle);
  end

endmodule

`default_nettype wire

// ===== hdl/armed_quad_motor_mixer.sv =====
// armed quad x-frame motor mixer, top level
// a command passes the input register, the state update and the result register
// throughput: one command per cycle if no stall; single state update stage
// input register and result register each hold one item under backpressure
// reset: pipeline empty, disarmed, all terms zero, registers to defaults
`default_nettype none

module armed_quad_motor_mixer
  import aqmm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [IdxW-1:0]        cfg_index_i,
  input  wire logic [RegW-1:0]        cfg_data_i,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire logic                   takeoff_req_i,
  input  wire logic                   emergency_req_i,
  input  wire logic signed [ReqW-1:0] pitch_req_i,
  input  wire logic signed [ReqW-1:0] roll_req_i,
  input  wire logic signed [ReqW-1:0] yaw_req_i,
  input  wire logic signed [ReqW-1:0] climb_req_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic [MotW-1:0]        motor_front_left_o,
  output      logic [MotW-1:0]        motor_front_right_o,
  output      logic [MotW-1:0]        motor_rear_left_o,
  output      logic [MotW-1:0]        motor_rear_right_o,
  output      logic                   armed_o
);

  cfg_t    cfg;
  cmd_t    cmd_q;
  state_t  state_d;
  motors_t motors;
  motors_t motors_q;
  logic    armed_q;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    step;

  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~in_valid_q | step;

  aqmm_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  aqmm_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .cmd_i     (cmd_q),
    .cfg_i     (cfg),
    .state_d_o (state_d)
  );

  aqmm_mixer u_mixer (
    .state_i  (state_d),
    .cfg_i    (cfg),
    .motors_o (motors)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q.takeoff   <= takeoff_req_i;
      cmd_q.emergency <= emergency_req_i;
      cmd_q.pitch     <= pitch_req_i;
      cmd_q.roll      <= roll_req_i;
      cmd_q.yaw       <= yaw_req_i;
      cmd_q.climb     <= climb_req_i;
    end
    if (step) begin
      motors_q <= motors;
      armed_q  <= state_d.armed;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign motor_front_left_o  = motors_q.fwd_l;
  assign motor_front_right_o = motors_q.fwd_r;
  assign motor_rear_left_o   = motors_q.aft_l;
  assign motor_rear_right_o  = motors_q.aft_r;
  assign armed_o             = armed_q;

endmodule

`default_nettype wire

// ===== hdl/aqmm_checker.sv =====
// port-level checker for the motor mixer, bound to the top level
// depends on aqmm_pkg and armed_quad_motor_mixer_assert.svh
`default_nettype none
`include "armed_quad_motor_mixer_assert.svh"

module aqmm_checker
  import aqmm_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_ready_o,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire logic [MotW-1:0] motor_front_left_o,
  input wire logic [MotW-1:0] motor_front_right_o,
  input wire logic [MotW-1:0] motor_rear_left_o,
  input wire logic [MotW-1:0] motor_rear_right_o,
  input wire logic            armed_o
);

  `AQMM_ASSERT(a_out_valid_holds, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  `AQMM_ASSERT(a_out_payload_holds,
    out_valid_o && !out_ready_i |=> $stable(motor_front_left_o) && $stable(motor_front_right_o)
    && $stable(motor_rear_left_o) && $stable(motor_rear_right_o) && $stable(armed_o),
    "stalled result changed")

  // an empty result register never blocks a command
  `AQMM_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input blocked while empty")

  `AQMM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind armed_quad_motor_mixer aqmm_checker u_checker (.*);

`default_nettype wire

// ===== tb/armed_quad_motor_mixer_checker.sv =====
// checker for the armed quad motor mixer: follows config, command and motor transactions,
// predicts each motor result from its own copy of limits and flight state, and compares
// depends on aqmm_pkg for widths, register indexes, reset values and record types
module armed_quad_motor_mixer_checker
  import aqmm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [IdxW-1:0]        cfg_index_i,
  input  logic [RegW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   takeoff_req_i,
  input  logic                   emergency_req_i,
  input  logic signed [ReqW-1:0] pitch_req_i,
  input  logic signed [ReqW-1:0] roll_req_i,
  input  logic signed [ReqW-1:0] yaw_req_i,
  input  logic signed [ReqW-1:0] climb_req_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [MotW-1:0]        motor_front_left_i,
  input  logic [MotW-1:0]        motor_front_right_i,
  input  logic [MotW-1:0]        motor_rear_left_i,
  input  logic [MotW-1:0]        motor_rear_right_i,
  input  logic                   armed_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    motors_t motors;
    logic    armed;
  } mix_result_t;

  cfg_t        limits_q;
  state_t      flight_q;
  mix_result_t expected_q[$];
  int          fail_cnt;

  function automatic logic signed [TermW-1:0] bound_req(logic signed [ReqW-1:0] req,
                                                        logic [RegW-1:0] lim);
    int v;
    int l;
    v = req;
    l = lim;
    if (v < -l) begin
      v = -l;
    end else if (v > l) begin
      v = l;
    end
    return TermW'(v);
  endfunction

  function automatic logic [MotW-1:0] mix_speed(logic [TermW-1:0] thr, int mix,
                                                logic [RegW-1:0] lim);
    int l;
    int t;
    l = lim;
    t = thr;
    if (mix < 0) begin
      mix = 0;
    end else if (mix > l) begin
      mix = l;
    end
    return MotW'(t + mix);
  endfunction

  // advances the flight state by one command and gives the four motor speeds
  function automatic mix_result_t mix_command(cmd_t cmd);
    mix_result_t res;
    int thr;
    int p;
    int r;
    int y;
    if (cmd.takeoff) begin
      flight_q.armed = 1'b1;
    end
    if (cmd.emergency) begin
      flight_q = '0;
    end
    if (flight_q.armed) begin
      flight_q.pitch = bound_req(cmd.pitch, limits_q.pitch_roll_limit);
      flight_q.roll  = bound_req(cmd.roll, limits_q.pitch_roll_limit);
      flight_q.yaw   = bound_req(cmd.yaw, limits_q.yaw_limit);
      thr = flight_q.throttle;
      thr = thr + bound_req(cmd.climb, limits_q.climb_step_limit);
      if (thr < int'(limits_q.min_throttle)) begin
        thr = limits_q.min_throttle;
      end
      if (thr > int'(limits_q.max_throttle)) begin
        thr = limits_q.max_throttle;
      end
      flight_q.throttle = TermW'(thr);
    end
    p = $signed(flight_q.pitch);
    r = $signed(flight_q.roll);
    y = $signed(flight_q.yaw);
    res.motors.fwd_l = mix_speed(flight_q.throttle, -p + r - y, limits_q.mix_limit);
    res.motors.fwd_r = mix_speed(flight_q.throttle, -p - r + y, limits_q.mix_limit);
    res.motors.aft_l = mix_speed(flight_q.throttle, p + r + y, limits_q.mix_limit);
    res.motors.aft_r = mix_speed(flight_q.throttle, p - r - y, limits_q.mix_limit);
    res.armed = flight_q.armed;
    return res;
  endfunction

  function automatic void check_field(string name, logic [MotW-1:0] want,
                                      logic [MotW-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    cmd_t        cmd;
    mix_result_t got;
    mix_result_t want;
    if (!rst_ni) begin
      limits_q = '{RstPitchRollLimit, RstYawLimit, RstClimbStepLimit,
                   RstMinThrottle, RstMaxThrottle, RstMixLimit};
      flight_q = '0;
      expected_q.delete();
      fail_cnt = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegPitchRollLimit: limits_q.pitch_roll_limit = cfg_data_i;
          RegYawLimit:       limits_q.yaw_limit = cfg_data_i;
          RegClimbStepLimit: limits_q.climb_step_limit = cfg_data_i;
          RegMinThrottle:    limits_q.min_throttle = cfg_data_i;
          RegMaxThrottle:    limits_q.max_throttle = cfg_data_i;
          RegMixLimit:       limits_q.mix_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        cmd.takeoff   = takeoff_req_i;
        cmd.emergency = emergency_req_i;
        cmd.pitch     = pitch_req_i;
        cmd.roll      = roll_req_i;
        cmd.yaw       = yaw_req_i;
        cmd.climb     = climb_req_i;
        expected_q.insert(expected_q.size(), mix_command(cmd));
      end
      if (out_valid_i && out_ready_i) begin
        got.motors.fwd_l = motor_front_left_i;
        got.motors.fwd_r = motor_front_right_i;
        got.motors.aft_l = motor_rear_left_i;
        got.motors.aft_r = motor_rear_right_i;
        got.armed        = armed_i;
        if (expected_q.size() == 0) begin
          $error("motor result transaction with no command pending");
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          check_field("motor_front_left", want.motors.fwd_l, got.motors.fwd_l);
          check_field("motor_front_right", want.motors.fwd_r, got.motors.fwd_r);
          check_field("motor_rear_left", want.motors.aft_l, got.motors.aft_l);
          check_field("motor_rear_right", want.motors.aft_r, got.motors.aft_r);
          check_field("armed", MotW'(want.armed), MotW'(got.armed));
        end
      end
      pending_o <= expected_q.size();
      fail_count_o <= fail_cnt;
    end
  end

endmodule

// ===== tb/tb.sv =====
// top of the motor mixer testbench: clock, reset, command and config stimulus, result sink
// depends on aqmm_pkg, armed_quad_motor_mixer and armed_quad_motor_mixer_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aqmm_pkg::*;

  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned PhaseCount  = 10;

  localparam logic [IdxW-1:0] RegUnknownLo = 3'd6;
  localparam logic [IdxW-1:0] RegUnknownHi = 3'd7;

  localparam logic signed [ReqW-1:0] ReqMax = 16'sh7fff;
  localparam logic signed [ReqW-1:0] ReqMin = 16'sh8000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [IdxW-1:0]        cfg_index;
  logic [RegW-1:0]        cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   takeoff_req;
  logic                   emergency_req;
  logic signed [ReqW-1:0] pitch_req;
  logic signed [ReqW-1:0] roll_req;
  logic signed [ReqW-1:0] yaw_req;
  logic signed [ReqW-1:0] climb_req;
  logic                   out_valid;
  logic                   out_ready;
  logic [MotW-1:0]        motor_fl;
  logic [MotW-1:0]        motor_fr;
  logic [MotW-1:0]        motor_rl;
  logic [MotW-1:0]        motor_rr;
  logic                   armed;
  int                     fail_count;
  int                     pending;
  int unsigned            in_gap_max;
  int unsigned            out_gap_max;
  int unsigned            cycle_cnt = 0;

  armed_quad_motor_mixer uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .takeoff_req_i       (takeoff_req),
    .emergency_req_i     (emergency_req),
    .pitch_req_i         (pitch_req),
    .roll_req_i          (roll_req),
    .yaw_req_i           (yaw_req),
    .climb_req_i         (climb_req),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .motor_front_left_o  (motor_fl),
    .motor_front_right_o (motor_fr),
    .motor_rear_left_o   (motor_rl),
    .motor_rear_right_o  (motor_rr),
    .armed_o             (armed)
  );

  armed_quad_motor_mixer_checker chk (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .takeoff_req_i       (takeoff_req),
    .emergency_req_i     (emergency_req),
    .pitch_req_i         (pitch_req),
    .roll_req_i          (roll_req),
    .yaw_req_i           (yaw_req),
    .climb_req_i         (climb_req),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .motor_front_left_i  (motor_fl),
    .motor_front_right_i (motor_fr),
    .motor_rear_left_i   (motor_rl),
    .motor_rear_right_i  (motor_rr),
    .armed_i             (armed),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(logic to, logic em, logic signed [ReqW-1:0] p, r, y, c);
    cmd_t cmd;
    cmd.takeoff   = to;
    cmd.emergency = em;
    cmd.pitch     = p;
    cmd.roll      = r;
    cmd.yaw       = y;
    cmd.climb     = c;
    return cmd;
  endfunction

  // mostly values near the limits, some extremes and some full-range noise
  function automatic logic signed [ReqW-1:0] random_req();
    case ($urandom_range(0, 7))
      0: return ReqMax;
      1: return ReqMin;
      2, 3, 4: return ReqW'(int'($urandom_range(0, 1200)) - 600);
      5: return ReqW'(int'($urandom_range(0, 20)) - 10);
      default: return ReqW'($urandom);
    endcase
  endfunction

  // arming is common and emergency rare so most commands reach the armed path
  function automatic cmd_t random_cmd();
    cmd_t cmd;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    cmd.takeoff   = (sel < 10);
    cmd.emergency = (sel >= 7 && sel < 12);
    if ($urandom_range(0, 9) == 0) begin
      {cmd.takeoff, cmd.emergency} = 2'($urandom);
    end
    cmd.pitch = random_req();
    cmd.roll  = random_req();
    cmd.yaw   = random_req();
    cmd.climb = random_req();
    return cmd;
  endfunction

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [RegW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input cfg_t lim);
    write_reg(RegPitchRollLimit, lim.pitch_roll_limit);
    write_reg(RegYawLimit, lim.yaw_limit);
    write_reg(RegClimbStepLimit, lim.climb_step_limit);
    write_reg(RegMinThrottle, lim.min_throttle);
    write_reg(RegMaxThrottle, lim.max_throttle);
    write_reg(RegMixLimit, lim.mix_limit);
    write_reg(RegUnknownLo, RegW'($urandom));
    write_reg(RegUnknownHi, RegW'($urandom));
  endtask

  task automatic send_cmd(input cmd_t cmd);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    takeoff_req   <= cmd.takeoff;
    emergency_req <= cmd.emergency;
    pitch_req     <= cmd.pitch;
    roll_req      <= cmd.roll;
    yaw_req       <= cmd.yaw;
    climb_req     <= cmd.climb;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_commands();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    cfg_t lim;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    takeoff_req   = 1'b0;
    emergency_req = 1'b0;
    pitch_req     = '0;
    roll_req      = '0;
    yaw_req       = '0;
    climb_req     = '0;
    in_gap_max    = 0;
    out_gap_max   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: disarmed hold, arming, extremes, emergency with and without takeoff
    send_cmd(make_cmd(1'b0, 1'b0, '0, '0, '0, '0));
    send_cmd(make_cmd(1'b0, 1'b0, ReqMax, ReqMin, ReqMax, ReqMax));
    send_cmd(make_cmd(1'b1, 1'b0, ReqMax, ReqMin, ReqMax, ReqMax));
    send_cmd(make_cmd(1'b0, 1'b0, ReqMin, ReqMax, ReqMin, ReqMin));
    send_cmd(make_cmd(1'b0, 1'b0, '0, '0, '0, 16'sd3));
    send_cmd(make_cmd(1'b0, 1'b0, 16'sd150, -16'sd150, 16'sd1, -16'sd1));
    send_cmd(make_cmd(1'b0, 1'b0, -16'sd201, 16'sd201, -16'sd2, 16'sd4));
    send_cmd(make_cmd(1'b1, 1'b1, ReqMax, ReqMax, ReqMax, ReqMax));
    send_cmd(make_cmd(1'b0, 1'b0, 16'sd100, 16'sd50, 16'sd1, 16'sd3));
    send_cmd(make_cmd(1'b1, 1'b0, 16'sd10, -16'sd20, -16'sd1, 16'sd2));
    send_cmd(make_cmd(1'b1, 1'b0, -16'sd10, 16'sd20, 16'sd1, 16'sd3));
    send_cmd(make_cmd(1'b0, 1'b1, 16'sd5, 16'sd5, 16'sd5, 16'sd5));
    send_cmd(make_cmd(1'b0, 1'b1, ReqMin, ReqMin, ReqMin, ReqMin));
    drain_commands();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: lim = '{RstPitchRollLimit, RstYawLimit, RstClimbStepLimit,
                   RstMinThrottle, RstMaxThrottle, RstMixLimit};
        1: lim = '{9'd200, 9'd40, 9'd20, 9'd50, 9'd400, 9'd300};
        2: lim = '0;
        3: lim = '1;
        4: lim = '{9'd100, 9'd30, 9'd60, 9'd400, 9'd100, 9'd200};
        5: lim = '{9'd1, 9'd1, 9'd1, 9'd0, 9'd511, 9'd1};
        default: lim = cfg_t'(54'({$urandom, $urandom}));
      endcase
      set_limits(lim);
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 7;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      repeat (PhaseItems) send_cmd(random_cmd());
      drain_commands();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/aqmm_pkg.sv
hdl/aqmm_cfg_regs.sv
hdl/aqmm_state.sv
hdl/aqmm_mixer.sv
hdl/armed_quad_motor_mixer.sv
hdl/aqmm_checker.sv
tb/armed_quad_motor_mixer_checker.sv
tb/tb.sv
